### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/upf_pkg.sv
`default_nettype none

package upf_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RELAY = 2'd1,
        CMD_OWN   = 2'd2,
        CMD_DONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_SENT       = 3'd0,
        ST_BUSY_DROP  = 3'd1,
        ST_NO_PARENT  = 3'd2,
        ST_WRITTEN    = 3'd3,
        ST_COMPLETION = 3'd4
    } status_t;

    localparam logic       CFG_OWN_GRADIENT = 1'b0;
    localparam logic       CFG_OWN_ADDRESS  = 1'b1;

    localparam logic [7:0]  GRAD_NONE       = 8'd255;
    localparam logic [15:0] ADDR_UNASSIGNED = 16'd0;
    localparam logic [7:0]  HOPS_OWN        = 8'd1;

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = 1;
    localparam int QC_W    = 2;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  entry_index;
        logic        in_range;
        logic        entry_valid;
        logic [31:0] entry_word;
        logic [15:0] exclude;
        logic [15:0] source;
        logic [15:0] payload;
        logic [7:0]  hops;
        logic [31:0] time_stamp;
        logic        send_ok;
    } q_item_t;

    typedef struct packed {
        logic scanning;
        logic load_sent;
        logic busy;
    } back_stat_t;

endpackage

`default_nettype wire

### sv/upf_front.sv
`default_nettype none

module upf_front #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [127:0]       s_tdata,
    input  wire logic [1:0]         s_tuser,
    input  wire logic [15:0]        own_address,
    input  wire logic               q_full,
    output logic                    q_push,
    output upf_pkg::q_item_t        q_item
);
    import upf_pkg::*;

    cmd_t        cmd;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [15:0] entry_address;
    logic [7:0]  entry_gradient;
    logic [7:0]  entry_rssi;
    logic [15:0] sender_address;
    logic [15:0] payload_word;
    logic [15:0] origin_address;
    logic [7:0]  hops_received;
    logic [31:0] time_stamp;
    logic        send_failed;
    logic        relay;

    assign cmd            = cmd_t'(s_tuser);
    assign entry_index    = s_tdata[3:0];
    assign entry_valid    = s_tdata[4];
    assign entry_address  = s_tdata[20:5];
    assign entry_gradient = s_tdata[28:21];
    assign entry_rssi     = s_tdata[36:29];
    assign sender_address = s_tdata[52:37];
    assign payload_word   = s_tdata[68:53];
    assign origin_address = s_tdata[84:69];
    assign hops_received  = s_tdata[92:85];
    assign time_stamp     = s_tdata[124:93];
    assign send_failed    = s_tdata[125];

    assign relay    = (cmd == CMD_RELAY);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.cmd         = cmd;
        q_item.entry_index = entry_index;
        q_item.in_range    = (32'(entry_index) < 32'(TABLE_DEPTH));
        q_item.entry_valid = entry_valid;
        q_item.entry_word  = {entry_rssi, entry_gradient, entry_address};
        q_item.exclude     = relay ? sender_address : ADDR_UNASSIGNED;
        q_item.source      = relay ? origin_address : own_address;
        q_item.payload     = payload_word;
        q_item.hops        = relay ? (hops_received + 8'd1) : HOPS_OWN;
        q_item.time_stamp  = time_stamp;
        q_item.send_ok     = !send_failed;
    end

endmodule

`default_nettype wire

### sv/upf_queue.sv
`default_nettype none

module upf_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire upf_pkg::q_item_t   push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    pop_valid,
    output upf_pkg::q_item_t        pop_item
);
    import upf_pkg::*;

    q_item_t           mem_reg [Q_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QC_W'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QC_W'(push) - QC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### sv/upf_back.sv
`default_nettype none

module upf_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         own_gradient,
    input  wire logic               q_valid,
    input  wire upf_pkg::q_item_t   q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [95:0]             m_tdata,
    output logic [2:0]              m_tuser,
    output upf_pkg::back_stat_t     stat
);
    import upf_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               busy_reg, busy_next;
    logic [15:0]        prev_reg, prev_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_live_reg, rd_live_next;
    logic               found_reg, found_next;
    logic [15:0]        best_addr_reg, best_addr_next;
    logic [7:0]         best_grad_reg, best_grad_next;
    logic [7:0]         best_rssi_reg, best_rssi_next;
    q_item_t            cur_reg, cur_next;

    logic               m_valid_reg, m_valid_next;
    status_t            o_status_reg, o_status_next;
    logic [15:0]        o_hop_reg, o_hop_next;
    logic [15:0]        o_src_reg, o_src_next;
    logic [15:0]        o_pay_reg, o_pay_next;
    logic [7:0]         o_hops_reg, o_hops_next;
    logic [31:0]        o_time_reg, o_time_next;
    logic               o_chg_reg, o_chg_next;
    logic               o_ok_reg, o_ok_next;

    logic [31:0]          mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0]          rd_word_reg;
    logic                 rd_vbit_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W+3:0]     idx_wide;
    logic [IDX_W-1:0]     wr_addr;
    logic                 mem_we;
    logic                 out_free;
    logic                 cand;
    logic                 better;
    logic                 load_sent;
    logic [15:0]          rd_a;
    logic [7:0]           rd_g;
    logic [7:0]           rd_r;

    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign idx_wide = (IDX_W + 4)'(q_item.entry_index);
    assign wr_addr  = idx_wide[IDX_W-1:0];
    assign out_free = !m_valid_reg || m_tready;

    assign rd_a = rd_word_reg[15:0];
    assign rd_g = rd_word_reg[23:16];
    assign rd_r = rd_word_reg[31:24];

    assign cand   = rd_live_reg && rd_vbit_reg && (rd_a != cur_reg.exclude)
                    && (rd_g < own_gradient);
    assign better = !found_reg || (rd_g < best_grad_reg)
                    || ((rd_g == best_grad_reg) && ($signed(rd_r) > $signed(best_rssi_reg)));

    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        rd_live_next   = 1'b0;
        found_next     = found_reg;
        best_addr_next = best_addr_reg;
        best_grad_next = best_grad_reg;
        best_rssi_next = best_rssi_reg;
        cur_next       = cur_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        o_status_next  = o_status_reg;
        o_hop_next     = o_hop_reg;
        o_src_next     = o_src_reg;
        o_pay_next     = o_pay_reg;
        o_hops_next    = o_hops_reg;
        o_time_next    = o_time_reg;
        o_chg_next     = o_chg_reg;
        o_ok_next      = o_ok_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        load_sent      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop       = 1'b1;
                    o_hop_next  = '0;
                    o_src_next  = '0;
                    o_pay_next  = '0;
                    o_hops_next = '0;
                    o_time_next = '0;
                    o_chg_next  = 1'b0;
                    o_ok_next   = 1'b0;
                    unique case (q_item.cmd)
                        CMD_WRITE: begin
                            mem_we        = q_item.in_range;
                            m_valid_next  = 1'b1;
                            o_status_next = ST_WRITTEN;
                        end
                        CMD_DONE: begin
                            busy_next     = 1'b0;
                            m_valid_next  = 1'b1;
                            o_status_next = ST_COMPLETION;
                            o_ok_next     = q_item.send_ok;
                        end
                        CMD_RELAY, CMD_OWN: begin
                            if (busy_reg) begin
                                m_valid_next  = 1'b1;
                                o_status_next = ST_BUSY_DROP;
                            end else if (own_gradient == GRAD_NONE) begin
                                m_valid_next  = 1'b1;
                                o_status_next = ST_NO_PARENT;
                            end else begin
                                cur_next   = q_item;
                                cnt_next   = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    rd_live_next = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (cand && better) begin
                    found_next     = 1'b1;
                    best_addr_next = rd_a;
                    best_grad_next = rd_g;
                    best_rssi_next = rd_r;
                end
                if ((cnt_reg == CNT_W'(TABLE_DEPTH)) && !rd_live_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    o_ok_next    = 1'b0;
                    if (found_reg) begin
                        load_sent     = 1'b1;
                        busy_next     = 1'b1;
                        prev_next     = best_addr_reg;
                        o_status_next = ST_SENT;
                        o_hop_next    = best_addr_reg;
                        o_src_next    = cur_reg.source;
                        o_pay_next    = cur_reg.payload;
                        o_hops_next   = cur_reg.hops;
                        o_time_next   = cur_reg.time_stamp;
                        o_chg_next    = (prev_reg != ADDR_UNASSIGNED)
                                        && (prev_reg != best_addr_reg);
                    end else begin
                        o_status_next = ST_NO_PARENT;
                        o_hop_next    = '0;
                        o_src_next    = '0;
                        o_pay_next    = '0;
                        o_hops_next   = '0;
                        o_time_next   = '0;
                        o_chg_next    = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            prev_reg    <= ADDR_UNASSIGNED;
            cnt_reg     <= '0;
            rd_live_reg <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            prev_reg    <= prev_next;
            cnt_reg     <= cnt_next;
            rd_live_reg <= rd_live_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        best_addr_reg <= best_addr_next;
        best_grad_reg <= best_grad_next;
        best_rssi_reg <= best_rssi_next;
        cur_reg       <= cur_next;
        o_status_reg  <= o_status_next;
        o_hop_reg     <= o_hop_next;
        o_src_reg     <= o_src_next;
        o_pay_reg     <= o_pay_next;
        o_hops_reg    <= o_hops_next;
        o_time_reg    <= o_time_next;
        o_chg_reg     <= o_chg_next;
        o_ok_reg      <= o_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[wr_addr] <= q_item.entry_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_item.entry_word;
        end
        rd_word_reg <= mem[rd_addr];
        rd_vbit_reg <= valid_reg[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {6'd0, o_ok_reg, o_chg_reg, o_time_reg, o_hops_reg,
                       o_pay_reg, o_src_reg, o_hop_reg};

    assign stat.scanning  = (state_reg == S_SCAN);
    assign stat.load_sent = load_sent;
    assign stat.busy      = busy_reg;

endmodule

`default_nettype wire

### sv/upstream_parent_forwarder.sv
// Channel | Dir | Handshake          | Contents
// s_      | in  | s_tvalid/s_tready  | tuser: command; tdata: table-write and packet fields
// m_      | out | m_tvalid/m_tready  | tuser: status; tdata: frame fields and flags
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index selects register, cfg_data carries value
//
// Table write, completion, busy drop and uninitialized-node items: answered from idle in the back end.
// Relay and own-send items: a table scan of one slot per cycle, then the result frame; the scan
// goes through the single read port of the neighbor table.
// Reset clears control state and all slot valid bits; no clearing pass.
// A two-entry queue takes input items while the back end scans or the output waits.
`default_nettype none
`include "assert_macros.svh"

module upstream_parent_forwarder #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [3:0] entry_index, [4] entry_valid, [20:5] entry_address, [28:21] entry_gradient,
    // [36:29] entry_rssi, [52:37] sender_address, [68:53] payload_word,
    // [84:69] origin_address, [92:85] hops_received, [124:93] time_stamp,
    // [125] send_failed, [127:126] zero
    input  wire logic [127:0]  s_tdata,
    // [1:0] command
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [15:0] next_hop_address, [31:16] frame_source, [47:32] frame_payload,
    // [55:48] frame_hops, [87:56] frame_time, [88] route_changed, [89] send_ok,
    // [95:90] zero
    output logic [95:0]        m_tdata,
    // [2:0] status
    output logic [2:0]         m_tuser,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import upf_pkg::*;

    logic [7:0]   own_gradient_reg, own_gradient_next;
    logic [15:0]  own_address_reg, own_address_next;
    logic         q_full;
    logic         q_push;
    q_item_t      push_item;
    logic         q_pop;
    logic         q_valid;
    q_item_t      pop_item;
    back_stat_t   back_stat;

    assign cfg_ready = 1'b1;

    always_comb begin
        own_gradient_next = own_gradient_reg;
        own_address_next  = own_address_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index[0] == CFG_OWN_GRADIENT) begin
                own_gradient_next = cfg_data[7:0];
            end else if (cfg_index[0] == CFG_OWN_ADDRESS) begin
                own_address_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_gradient_reg <= GRAD_NONE;
            own_address_reg  <= 16'd0;
        end else begin
            own_gradient_reg <= own_gradient_next;
            own_address_reg  <= own_address_next;
        end
    end

    upf_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .own_address (own_address_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    upf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    upf_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .own_gradient (own_gradient_reg),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .stat         (back_stat)
    );

    `ASSERT_IMPLIES(a_chg_only_sent, aclk, aresetn, m_tvalid && m_tdata[88], m_tuser == ST_SENT)
    `ASSERT_IMPLIES(a_no_pop_in_scan, aclk, aresetn, back_stat.scanning, !q_pop)
    `ASSERT_NEXT(a_sent_sets_busy, aclk, aresetn, back_stat.load_sent, back_stat.busy)

endmodule

`default_nettype wire
